// ----- rtl/mprc_pkg.sv -----
package mprc_pkg;

    // Field widths
    localparam int RES_W = 10;
    localparam int PIX_W = 8;
    localparam int CFG_W = 12;
    localparam int ROW_W = 11;

    // Default line store depth
    localparam int MAX_WIDTH_DEF = 2048;

    // Largest frame height in rows
    localparam logic [CFG_W-1:0] MAX_HEIGHT = 12'd2048;

    // Top of the pixel range
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    // Configuration register indexes
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    // Position flags handed to the predictor
    typedef struct packed {
        logic first_row;
        logic first_col;
    } pred_ctl_t;

    // One result item
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             end_of_row;
        logic             end_of_frame;
    } pix_item_t;

endpackage

// ----- rtl/med_predictive_pixel_reconstruct.sv -----
// Channel   Direction  Signals                                   Item
// -------   ---------  ----------------------------------------  -----------------------
// input     in         in_valid, in_ready, residual              one residual, raster order
// output    out        out_valid, out_ready, pixel,              one rebuilt pixel
//                      end_of_row, end_of_frame
// config    in         cfg_we, cfg_index, cfg_data               frame_width, frame_height
//
// One item per cycle sustained while the output is not stalled; a pixel is registered
// at the edge that takes its residual. The line store read for the next column is
// issued in the cycle the current item is taken, so its registered read data is ready
// for the next item. After reset and in the cycle after each configuration write,
// in_ready is low while the line store read for the current column is refetched.
// An output stall is absorbed by one skid entry; in_ready drops once that entry fills.
module med_predictive_pixel_reconstruct #(
    parameter int MAX_WIDTH = mprc_pkg::MAX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic        [mprc_pkg::CFG_W-1:0] cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [mprc_pkg::RES_W-1:0] residual,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic        [mprc_pkg::PIX_W-1:0] pixel,
    output logic                              end_of_row,
    output logic                              end_of_frame
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > mprc_pkg::CFG_W) ? WW : mprc_pkg::CFG_W;
    localparam int RW   = mprc_pkg::ROW_W;
    localparam int PW   = mprc_pkg::PIX_W;

    logic [mprc_pkg::CFG_W-1:0] frame_width_reg;
    logic [mprc_pkg::CFG_W-1:0] frame_width_next;
    logic [mprc_pkg::CFG_W-1:0] frame_height_reg;
    logic [mprc_pkg::CFG_W-1:0] frame_height_next;
    logic                       hold_reg;
    logic [CW-1:0]              col_reg;
    logic [CW-1:0]              col_next;
    logic [RW-1:0]              row_reg;
    logic [RW-1:0]              row_next;
    logic [PW-1:0]              left_reg;
    logic [PW-1:0]              left_next;
    logic [PW-1:0]              ul_reg;
    logic [PW-1:0]              ul_next;
    logic                       fwd_reg;
    logic                       fwd_next;
    logic [PW-1:0]              fwd_data_reg;

    logic [CMPW-1:0]            w_cmp;
    logic [WW-1:0]              w_eff;
    logic [WW-1:0]              w_m1;
    logic [mprc_pkg::CFG_W-1:0] h_eff;
    logic [RW-1:0]              h_m1;
    logic [CW-1:0]              col_eff;
    logic [RW-1:0]              row_eff;
    logic                       eor;
    logic                       eof;
    logic                       accept;
    logic                       obuf_ready;
    logic [CW-1:0]              col_step;
    logic [CW-1:0]              rd_addr;
    logic [PW-1:0]              rd_data;
    logic [PW-1:0]              above;
    logic [PW-1:0]              value;
    mprc_pkg::pred_ctl_t        ctl;
    mprc_pkg::pix_item_t        item;
    mprc_pkg::pix_item_t        out_item;

    // Configuration registers
    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                mprc_pkg::CFG_FRAME_WIDTH:  frame_width_next  = cfg_data;
                mprc_pkg::CFG_FRAME_HEIGHT: frame_height_next = cfg_data;
                default:                    frame_width_next  = frame_width_reg;
            endcase
        end
    end

    // Effective frame size and position
    always_comb
    begin
        w_cmp = CMPW'(frame_width_reg);
        if (w_cmp == '0)
        begin
            w_eff = WW'(1);
        end
        else if (w_cmp > CMPW'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_cmp[WW-1:0];
        end
        w_m1 = w_eff - WW'(1);

        if (frame_height_reg == '0)
        begin
            h_eff = mprc_pkg::CFG_W'(1);
        end
        else if (frame_height_reg > mprc_pkg::MAX_HEIGHT)
        begin
            h_eff = mprc_pkg::MAX_HEIGHT;
        end
        else
        begin
            h_eff = frame_height_reg;
        end
        h_m1 = RW'(h_eff - mprc_pkg::CFG_W'(1));

        col_eff = (WW'(col_reg) >= w_eff) ? w_m1[CW-1:0] : col_reg;
        row_eff = (mprc_pkg::CFG_W'(row_reg) >= h_eff) ? h_m1 : row_reg;
        eor     = (WW'(col_eff) == w_m1);
        eof     = eor && (row_eff == h_m1);
    end

    assign in_ready = obuf_ready && !hold_reg;
    assign accept   = in_valid && in_ready;

    // Above pixel: forwarded when the last write hit the address just read
    assign above = fwd_reg ? fwd_data_reg : rd_data;

    assign ctl.first_row = (row_eff == '0);
    assign ctl.first_col = (col_eff == '0);

    mprc_predict u_predict (
        .residual       (residual),
        .left_pix       (left_reg),
        .above_pix      (above),
        .upper_left_pix (ul_reg),
        .ctl            (ctl),
        .value          (value)
    );

    // Position update and read address for the next item
    always_comb
    begin
        col_step  = eor ? '0 : (col_eff + CW'(1));
        col_next  = col_reg;
        row_next  = row_reg;
        left_next = left_reg;
        ul_next   = ul_reg;
        rd_addr   = col_eff;
        if (accept)
        begin
            col_next  = col_step;
            row_next  = eof ? '0 : (eor ? (row_eff + RW'(1)) : row_eff);
            left_next = value;
            ul_next   = above;
            rd_addr   = col_step;
        end
        fwd_next = accept && (col_step == col_eff);
    end

    mprc_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .clk   (clk),
        .we    (accept),
        .waddr (col_eff),
        .wdata (value),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= 12'd640;
            frame_height_reg <= 12'd480;
            hold_reg         <= 1'b1;
            col_reg          <= '0;
            row_reg          <= '0;
            left_reg         <= '0;
            ul_reg           <= '0;
            fwd_reg          <= 1'b0;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            hold_reg         <= cfg_we;
            col_reg          <= col_next;
            row_reg          <= row_next;
            left_reg         <= left_next;
            ul_reg           <= ul_next;
            fwd_reg          <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= value;
    end

    // Result item
    assign item.pixel        = value;
    assign item.end_of_row   = eor;
    assign item.end_of_frame = eof;

    mprc_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .item      (item),
        .can_push  (obuf_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    assign pixel        = out_item.pixel;
    assign end_of_row   = out_item.end_of_row;
    assign end_of_frame = out_item.end_of_frame;

`ifndef SYNTHESIS
    // frame end returns the position to the origin
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && eof) |=> (col_reg == '0 && row_reg == '0))
        else $error("position not cleared after end of frame");

    // inside a row the column steps by one
    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !eor) |=> (col_reg == ($past(col_eff) + CW'(1))))
        else $error("column did not advance by one");

    // forwarding only follows a taken item
    a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> $past(accept))
        else $error("forward flag without a preceding item");
`endif

endmodule

// ----- rtl/mprc_ram.sv -----
module mprc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/mprc_predict.sv -----
module mprc_predict (
    input  logic signed [mprc_pkg::RES_W-1:0] residual,
    input  logic        [mprc_pkg::PIX_W-1:0] left_pix,
    input  logic        [mprc_pkg::PIX_W-1:0] above_pix,
    input  logic        [mprc_pkg::PIX_W-1:0] upper_left_pix,
    input  mprc_pkg::pred_ctl_t               ctl,
    output logic        [mprc_pkg::PIX_W-1:0] value
);

    localparam int SW = 12;

    logic        [mprc_pkg::PIX_W-1:0] lo;
    logic        [mprc_pkg::PIX_W-1:0] hi;
    logic signed [SW-1:0]              grad;
    logic signed [SW-1:0]              pred;
    logic signed [SW-1:0]              sum;

    // Median edge detector, bypassed on the first row and column
    always_comb
    begin
        lo   = (left_pix < above_pix) ? left_pix : above_pix;
        hi   = (left_pix < above_pix) ? above_pix : left_pix;
        grad = $signed(SW'(left_pix)) + $signed(SW'(above_pix))
             - $signed(SW'(upper_left_pix));
        if (ctl.first_row && ctl.first_col)
        begin
            pred = '0;
        end
        else if (ctl.first_row)
        begin
            pred = $signed(SW'(left_pix));
        end
        else if (ctl.first_col)
        begin
            pred = $signed(SW'(above_pix));
        end
        else if (upper_left_pix >= hi)
        begin
            pred = $signed(SW'(lo));
        end
        else if (upper_left_pix <= lo)
        begin
            pred = $signed(SW'(hi));
        end
        else
        begin
            pred = grad;
        end
    end

    // Add residual and clamp to the pixel range
    always_comb
    begin
        sum = pred + SW'(residual);
        if (sum < 0)
        begin
            value = '0;
        end
        else if (sum > $signed(SW'(mprc_pkg::PIX_MAX)))
        begin
            value = mprc_pkg::PIX_MAX;
        end
        else
        begin
            value = sum[mprc_pkg::PIX_W-1:0];
        end
    end

endmodule

// ----- rtl/mprc_obuf.sv -----
module mprc_obuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mprc_pkg::pix_item_t item,
    output logic                can_push,
    output logic                out_valid,
    input  logic                out_ready,
    output mprc_pkg::pix_item_t out_item
);

    logic                out_valid_reg;
    logic                out_valid_next;
    mprc_pkg::pix_item_t out_item_reg;
    mprc_pkg::pix_item_t out_item_next;
    logic                skid_valid_reg;
    logic                skid_valid_next;
    mprc_pkg::pix_item_t skid_item_reg;
    mprc_pkg::pix_item_t skid_item_next;

    // Output register with one skid entry behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        skid_valid_next = skid_valid_reg;
        skid_item_next  = skid_item_reg;
        if (out_valid_reg && !out_ready)
        begin
            if (push)
            begin
                skid_valid_next = 1'b1;
                skid_item_next  = item;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_item_next   = skid_item_reg;
            skid_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = push;
            out_item_next  = item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTHESIS
    // skid entry only fills behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // a stalled output with a push keeps both entries
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && push) |=> (skid_valid_reg && out_valid_reg))
        else $error("item lost while output stalled");

    // a stalled output item stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_item_reg)))
        else $error("output item changed while stalled");
`endif

endmodule

// ----- test/tb_med_predictive_pixel_reconstruct.sv -----
`timescale 1ns / 1ps

module tb_med_predictive_pixel_reconstruct;

    localparam int RANDOM_ITEMS = 600;
    localparam int LONG_RUN     = 300;
    localparam int HOLD_CYCLES  = 80;
    localparam int STALL_LIMIT  = 4000;
    localparam int MAX_REPORTS  = 10;

    // Predicts rebuilt pixels and checks them in order
    class pixel_scoreboard;
        logic [mprc_pkg::PIX_W-1:0] line_buf [mprc_pkg::MAX_WIDTH_DEF];
        logic [mprc_pkg::PIX_W-1:0] left_pix;
        logic [mprc_pkg::PIX_W-1:0] upleft_pix;
        int unsigned                col_pos;
        int unsigned                row_pos;
        int unsigned                written_span;
        logic [mprc_pkg::CFG_W-1:0] width_reg;
        logic [mprc_pkg::CFG_W-1:0] height_reg;
        mprc_pkg::pix_item_t        pixel_q[$];
        int unsigned                residuals_taken;
        int unsigned                pixels_checked;
        int unsigned                frames_done;
        int unsigned                mismatches;

        function new();
            foreach (line_buf[i])
                line_buf[i] = '0;
            left_pix        = '0;
            upleft_pix      = '0;
            col_pos         = 0;
            row_pos         = 0;
            written_span    = 0;
            width_reg       = 12'd640;
            height_reg      = 12'd480;
            residuals_taken = 0;
            pixels_checked  = 0;
            frames_done     = 0;
            mismatches      = 0;
        endfunction

        function int unsigned act_width(logic [mprc_pkg::CFG_W-1:0] v);
            if (v == 0)
                return 1;
            if (v > mprc_pkg::MAX_WIDTH_DEF)
                return mprc_pkg::MAX_WIDTH_DEF;
            return v;
        endfunction

        function int unsigned act_height(logic [mprc_pkg::CFG_W-1:0] v);
            if (v == 0)
                return 1;
            if (v > mprc_pkg::MAX_HEIGHT)
                return mprc_pkg::MAX_HEIGHT;
            return v;
        endfunction

        // Line store is filled as a prefix; widening below the top row must stay inside it
        function bit width_is_safe(logic [mprc_pkg::CFG_W-1:0] w,
                                   logic [mprc_pkg::CFG_W-1:0] h);
            int unsigned eff_row;
            eff_row = (row_pos >= act_height(h)) ? act_height(h) - 1 : row_pos;
            return (eff_row == 0) || (act_width(w) <= written_span);
        endfunction

        function void write_reg(logic idx, logic [mprc_pkg::CFG_W-1:0] v);
            if (idx == mprc_pkg::CFG_FRAME_WIDTH)
                width_reg = v;
            else
                height_reg = v;
        endfunction

        function void note_residual(logic signed [mprc_pkg::RES_W-1:0] res);
            int unsigned         w, h, c, r;
            int                  above, left, upleft, lo, hi, pred, value;
            mprc_pkg::pix_item_t exp_pix;
            w = act_width(width_reg);
            h = act_height(height_reg);
            c = (col_pos >= w) ? w - 1 : col_pos;
            r = (row_pos >= h) ? h - 1 : row_pos;
            above  = int'(line_buf[c]);
            left   = int'(left_pix);
            upleft = int'(upleft_pix);

            // prediction by position, median edge detector inside the frame
            if (r == 0 && c == 0)
                pred = 0;
            else if (r == 0)
                pred = left;
            else if (c == 0)
                pred = above;
            else
            begin
                lo = (left < above) ? left : above;
                hi = (left < above) ? above : left;
                if (upleft >= hi)
                    pred = lo;
                else if (upleft <= lo)
                    pred = hi;
                else
                    pred = left + above - upleft;
            end
            value = pred + int'(res);
            if (value < 0)
                value = 0;
            else if (value > int'(mprc_pkg::PIX_MAX))
                value = int'(mprc_pkg::PIX_MAX);

            upleft_pix  = above[mprc_pkg::PIX_W-1:0];
            line_buf[c] = value[mprc_pkg::PIX_W-1:0];
            left_pix    = value[mprc_pkg::PIX_W-1:0];
            if (c + 1 > written_span)
                written_span = c + 1;

            exp_pix.pixel        = value[mprc_pkg::PIX_W-1:0];
            exp_pix.end_of_row   = (c == w - 1);
            exp_pix.end_of_frame = exp_pix.end_of_row && (r == h - 1);
            pixel_q = {pixel_q, exp_pix};
            residuals_taken++;

            // raster advance
            if (exp_pix.end_of_row)
            begin
                col_pos = 0;
                row_pos = exp_pix.end_of_frame ? 0 : r + 1;
            end
            else
            begin
                col_pos = c + 1;
                row_pos = r;
            end
        endfunction

        function void check_pixel(logic [mprc_pkg::PIX_W-1:0] pix, logic eor, logic eof);
            mprc_pkg::pix_item_t exp_pix;
            if (pixel_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected pixel=%0d eor=%0b eof=%0b at %0t", pix, eor, eof,
                             $realtime);
                return;
            end
            exp_pix = pixel_q.pop_front();
            pixels_checked++;
            if (eof === 1'b1)
                frames_done++;
            if (pix !== exp_pix.pixel || eor !== exp_pix.end_of_row
                || eof !== exp_pix.end_of_frame)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch at %0t: expected pixel=%0d eor=%0b eof=%0b, ",
                             $realtime, exp_pix.pixel, exp_pix.end_of_row,
                             exp_pix.end_of_frame,
                             "got pixel=%0d eor=%0b eof=%0b", pix, eor, eof);
            end
        endfunction

        function int unsigned pending();
            return pixel_q.size();
        endfunction
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_we;
    logic                              cfg_index;
    logic        [mprc_pkg::CFG_W-1:0] cfg_data;
    logic                              in_valid;
    logic                              in_ready;
    logic signed [mprc_pkg::RES_W-1:0] residual;
    logic                              out_valid;
    logic                              out_ready;
    logic        [mprc_pkg::PIX_W-1:0] pixel;
    logic                              end_of_row;
    logic                              end_of_frame;

    pixel_scoreboard sb;
    int              send_idle_pct;
    int              recv_stall_pct;
    int              hold_req;
    int              hold_seen;
    int              hold_left;
    int unsigned     cfg_writes;

    med_predictive_pixel_reconstruct u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .residual     (residual),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel        (pixel),
        .end_of_row   (end_of_row),
        .end_of_frame (end_of_frame)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Output side: random stalls, plus a long counted hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left = 0;
            hold_seen = hold_req;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Sample mid-cycle so the values are the ones the next edge takes
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_pixel(pixel, end_of_row, end_of_frame);
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(negedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // One residual item; returns at the edge that takes it
    task automatic send_residual(input logic signed [mprc_pkg::RES_W-1:0] res);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        residual <= res;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        sb.note_residual(res);
    endtask

    // Stop offering and wait for every predicted pixel to come out
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [mprc_pkg::CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
        cfg_writes++;
        @(posedge clk);
    endtask

    task automatic set_size(input logic [mprc_pkg::CFG_W-1:0] w,
                            input logic [mprc_pkg::CFG_W-1:0] h);
        write_reg(mprc_pkg::CFG_FRAME_WIDTH, w);
        write_reg(mprc_pkg::CFG_FRAME_HEIGHT, h);
    endtask

    function automatic logic signed [mprc_pkg::RES_W-1:0] pick_residual();
        case ($urandom_range(0, 9))
            0:       return 10'h200;
            1:       return 10'h1FF;
            2, 3:    return 10'($urandom_range(0, 1023));
            default: return 10'(int'($urandom_range(0, 63)) - 32);
        endcase
    endfunction

    function automatic logic [mprc_pkg::CFG_W-1:0] pick_width();
        case ($urandom_range(0, 11))
            0:       return 12'd0;
            1:       return 12'd4095;
            2:       return 12'd2048;
            3:       return 12'd1;
            default: return 12'($urandom_range(2, 40));
        endcase
    endfunction

    function automatic logic [mprc_pkg::CFG_W-1:0] pick_height();
        case ($urandom_range(0, 11))
            0:       return 12'd0;
            1:       return 12'd4095;
            2:       return 12'd2048;
            3:       return 12'd1;
            default: return 12'($urandom_range(2, 6));
        endcase
    endfunction

    initial
    begin : stimulus
        logic signed [mprc_pkg::RES_W-1:0] seq[$];
        logic        [mprc_pkg::CFG_W-1:0] w, h;
        int unsigned                       seg, rand_sent, n;

        sb             = new();
        cfg_we         = 1'b0;
        cfg_index      = mprc_pkg::CFG_FRAME_WIDTH;
        cfg_data       = '0;
        in_valid       = 1'b0;
        residual       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 0;
        cfg_writes     = 0;
        rst_n          = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset size, first pixel clamp high, top row clamp low
        seq = {10'h1FF, 10'h200, 10'sd100};
        foreach (seq[i])
            send_residual(seq[i]);
        drain();

        // Narrow the width mid-row: the current column becomes the last one
        set_size(12'd2, 12'd3);
        seq = {10'sd5, 10'sd60, -10'sd7, 10'sd200, -10'sd300};
        foreach (seq[i])
            send_residual(seq[i]);
        drain();

        // Zero sizes act as one: every pixel ends a frame
        set_size(12'd0, 12'd0);
        seq = {10'h3FF, 10'sd300};
        foreach (seq[i])
            send_residual(seq[i]);
        drain();

        // Oversize width, then shrink below the current column
        set_size(12'd4095, 12'd2);
        seq = {10'sd10, 10'sd20, -10'sd5, 10'sd1};
        foreach (seq[i])
            send_residual(seq[i]);
        drain();
        write_reg(mprc_pkg::CFG_FRAME_WIDTH, 12'd3);
        seq = {10'sd0, 10'sd3, -10'sd40, 10'sd90};
        foreach (seq[i])
            send_residual(seq[i]);
        drain();

        // Shrink the height below the current row
        set_size(12'd2, 12'd4);
        seq = {10'sd50, 10'sd100, -10'sd20, 10'sd30, 10'sd7};
        foreach (seq[i])
            send_residual(seq[i]);
        drain();
        write_reg(mprc_pkg::CFG_FRAME_HEIGHT, 12'd2);
        send_residual(-10'sd9);
        drain();

        // Random segments, sizes changed between them (often mid-frame)
        seg       = 0;
        rand_sent = 0;
        while (rand_sent < RANDOM_ITEMS)
        begin
            case ((seg / 3) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            w = pick_width();
            h = pick_height();
            if (!sb.width_is_safe(w, h))
                w = 12'($urandom_range(1, sb.written_span));
            set_size(w, h);
            if (seg == 1)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
                hold_req++;
            end
            n = $urandom_range(20, 120);
            repeat (n) send_residual(pick_residual());
            rand_sent += n;
            drain();
            seg++;
        end

        // Long row at the oversize width, then a long single-pixel column
        send_idle_pct  = 15;
        recv_stall_pct = 15;
        set_size(12'd4095, 12'd1);
        repeat (LONG_RUN) send_residual(pick_residual());
        drain();
        set_size(12'd1, 12'd4095);
        repeat (LONG_RUN) send_residual(pick_residual());
        drain();

        repeat (10) @(posedge clk);
        $display("run: %0d residuals, %0d pixels checked, %0d frames closed",
                 sb.residuals_taken, sb.pixels_checked, sb.frames_done);
        $display("     %0d random segments, %0d size writes incl. zero/oversize/mid-frame",
                 seg, cfg_writes);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
